// ===== rtl/fault_code_aging_lists_assert.svh =====
// Assertion macros for the fault code aging lists block.
// Used by the port checker; expects signals named clk and rst_n in scope.
`ifndef FAULT_CODE_AGING_LISTS_ASSERT_SVH
`define FAULT_CODE_AGING_LISTS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FCAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fcal_pkg.sv =====
// Shared types and constants for the fault code aging lists block.
// No dependencies; imported by every module of the block.
package fcal_pkg;

    localparam int CODE_W    = 8;
    localparam int LIFE_W    = 8;
    localparam int ENTRY_W   = CODE_W + LIFE_W;
    localparam int LIST_ID_W = 2;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 4;
    localparam int APP_W     = 2;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd12;

    // List identifiers, also the order in which lists are reported.
    localparam logic [LIST_ID_W-1:0] LIST_BATTERY = 2'd0;
    localparam logic [LIST_ID_W-1:0] LIST_MOTOR   = 2'd1;
    localparam logic [LIST_ID_W-1:0] LIST_OTHER   = 2'd2;

    // Code positions within one list unit, in the order they are applied.
    localparam logic [APP_W-1:0] APP_A = 2'd0;
    localparam logic [APP_W-1:0] APP_B = 2'd1;
    localparam logic [APP_W-1:0] APP_C = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_wr;
        logic start;
        logic scan;
        logic append;
        logic rep_rd;
        logic rep_load;
    } fcal_cmd_t;

    // Commands from the datapath to one list unit.
    typedef struct packed {
        logic start;
        logic scan;
        logic append;
        logic rep_rd;
        logic rep_load;
    } fcal_lcmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } fcal_sts_t;

endpackage

// ===== rtl/fault_code_aging_lists.sv =====
// Fault code aging lists: battery, motor and other lists with aging entries.
// Input channel in_valid/in_ready takes one frame: motor_code, battery_code and
// other_code_a..c. A zero code means none. The other list applies codes a, b, then c,
// in parallel with battery and motor; a live match is refreshed, a new code is appended.
// Output channel out_valid/out_ready returns 3 * LIST_DEPTH slot results per frame,
// battery list first, slots ascending; last marks the final one.
// Config channel cfg_valid/cfg_ready writes entry_lifetime (reset 12) while idle.
// Flow: after a frame transfer the lists are compacted in one scan of all LIST_DEPTH slots
// (all three list memories in parallel), then appended for code positions a, b and c.
// Results then follow one per cycle while the receiver does not stall, bound by the single
// read port of each list memory. A new frame is taken only after the report run ends.
// A stalled receiver holds the output register and pauses the report run; the next
// frame is accepted while the final result still waits in the output register.
// Reset empties all lists and loads the lifetime default; no clearing pass is run.
// Depends on fcal_pkg, fcal_ctrl and fcal_dp.
module fault_code_aging_lists #(
    parameter int LIST_DEPTH = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fcal_pkg::CODE_W-1:0]    motor_code,
    input  logic [fcal_pkg::CODE_W-1:0]    battery_code,
    input  logic [fcal_pkg::CODE_W-1:0]    other_code_a,
    input  logic [fcal_pkg::CODE_W-1:0]    other_code_b,
    input  logic [fcal_pkg::CODE_W-1:0]    other_code_c,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fcal_pkg::LIFE_W-1:0]    entry_lifetime,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fcal_pkg::LIST_ID_W-1:0] list_id,
    output logic [fcal_pkg::SLOT_W-1:0]    slot,
    output logic [fcal_pkg::CODE_W-1:0]    code,
    output logic                           live_flag,
    output logic [fcal_pkg::CNT_W-1:0]     live_count,
    output logic                           last
);
    import fcal_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);

    fcal_cmd_t            cmd;
    fcal_sts_t            sts;
    logic [AW-1:0]        slot_addr;
    logic [APP_W-1:0]     app_idx;
    logic [LIST_ID_W-1:0] list_sel;

    // Sequencer for one frame.
    fcal_ctrl #(.LIST_DEPTH(LIST_DEPTH)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .slot_addr (slot_addr),
        .app_idx   (app_idx),
        .list_sel  (list_sel)
    );

    // List storage and result path.
    fcal_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .slot_addr      (slot_addr),
        .app_idx        (app_idx),
        .list_sel       (list_sel),
        .entry_lifetime (entry_lifetime),
        .motor_code     (motor_code),
        .battery_code   (battery_code),
        .other_code_a   (other_code_a),
        .other_code_b   (other_code_b),
        .other_code_c   (other_code_c),
        .out_ready      (out_ready),
        .sts            (sts),
        .out_valid      (out_valid),
        .list_id        (list_id),
        .slot           (slot),
        .code           (code),
        .live_flag      (live_flag),
        .live_count     (live_count),
        .last           (last)
    );

endmodule

// ===== rtl/fcal_list.sv =====
// One fault code list: entry memory, compaction scan, appends and aging write-back.
// Depends on fcal_pkg.
module fcal_list #(
    parameter int DEPTH = 15,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcal_pkg::fcal_lcmd_t        cmd,
    input  logic [AW-1:0]               rd_addr,
    input  logic [fcal_pkg::APP_W-1:0]  app_idx,
    input  logic [fcal_pkg::CODE_W-1:0] code_a,
    input  logic [fcal_pkg::CODE_W-1:0] code_b,
    input  logic [fcal_pkg::CODE_W-1:0] code_c,
    input  logic [fcal_pkg::LIFE_W-1:0] lifetime,
    output logic [fcal_pkg::CODE_W-1:0] out_code,
    output logic                        out_live,
    output logic [CW-1:0]               out_cnt,
    output logic [AW-1:0]               out_slot
);
    import fcal_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_entry_reg;
    logic [AW-1:0]      rd_slot_reg;

    logic          scan_v_reg, scan_v_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] span_reg, span_next;
    logic [2:0]    found_reg, found_next;

    logic [CODE_W-1:0]  rd_code;
    logic [LIFE_W-1:0]  rd_life;
    logic               rd_live;
    logic               rd_en;
    logic               hit_a, hit_b, hit_c;
    logic               kill_early;
    logic [LIFE_W-1:0]  scan_life;
    logic               scan_wr;
    logic [CODE_W-1:0]  app_code;
    logic               app_found;
    logic               app_dup;
    logic               app_wr;
    logic               age_wr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // A slot at or beyond the span has not been written since the last update.
    assign rd_code = rd_entry_reg[ENTRY_W-1:LIFE_W];
    assign rd_life = rd_entry_reg[LIFE_W-1:0];
    assign rd_live = (CW'(rd_slot_reg) < span_reg) && (rd_life != '0);
    assign rd_en   = cmd.scan || cmd.rep_rd;

    // Match the slot being compacted against the pending codes.
    assign hit_a = rd_live && (code_a != '0) && (rd_code == code_a);
    assign hit_b = rd_live && (code_b != '0) && (rd_code == code_b);
    assign hit_c = rd_live && (code_c != '0) && (rd_code == code_c);

    // With a zero lifetime a slot hit by an earlier code is dropped by the same
    // compaction, while a slot hit only by the final code stays as a dead hole.
    assign kill_early = (hit_a || hit_b) && (lifetime == '0);
    assign scan_life  = (hit_a || hit_b || hit_c) ? lifetime : rd_life;
    assign scan_wr    = scan_v_reg && rd_live && !kill_early;

    // Append step for one code position.
    always_comb
    begin
        case (app_idx)
            APP_A:   app_code = code_a;
            APP_B:   app_code = code_b;
            default: app_code = code_c;
        endcase
    end

    assign app_found = found_reg[app_idx];
    assign app_dup   = ((app_idx == APP_B) && (code_b == code_a)) ||
                       ((app_idx == APP_C) && ((code_c == code_a) || (code_c == code_b)));
    assign app_wr    = cmd.append && (app_code != '0) && !app_found && !app_dup &&
                       (lifetime != '0) && (n_reg < CW'(DEPTH));

    // Aging write-back when the slot's result moves to the output register.
    assign age_wr = cmd.rep_load && rd_live;

    // Single write port shared by compaction, append and aging.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = n_reg[AW-1:0];
        wr_data = {rd_code, scan_life};
        if (scan_wr)
        begin
            wr_en = 1'b1;
        end
        else if (app_wr)
        begin
            wr_en   = 1'b1;
            wr_data = {app_code, lifetime};
        end
        else if (age_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = rd_slot_reg;
            wr_data = {rd_code, rd_life - LIFE_W'(1)};
        end
    end

    // Entry memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
            rd_slot_reg  <= rd_addr;
        end
    end

    // Write pointer, live count, span and match flags.
    always_comb
    begin
        scan_v_next = cmd.scan;
        n_next      = n_reg;
        cnt_next    = cnt_reg;
        span_next   = span_reg;
        found_next  = found_reg;
        if (cmd.start)
        begin
            n_next     = '0;
            cnt_next   = '0;
            found_next = '0;
        end
        if (scan_v_reg)
        begin
            found_next = found_reg | {hit_c, hit_b, hit_a};
        end
        if (scan_wr)
        begin
            n_next = n_reg + CW'(1);
            if (scan_life != '0)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
        if (app_wr)
        begin
            n_next   = n_reg + CW'(1);
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmd.append)
        begin
            span_next = n_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_v_reg <= 1'b0;
            n_reg      <= '0;
            cnt_reg    <= '0;
            span_reg   <= '0;
            found_reg  <= '0;
        end
        else
        begin
            scan_v_reg <= scan_v_next;
            n_reg      <= n_next;
            cnt_reg    <= cnt_next;
            span_reg   <= span_next;
            found_reg  <= found_next;
        end
    end

    assign out_code = rd_live ? rd_code : '0;
    assign out_live = rd_live;
    assign out_cnt  = cnt_reg;
    assign out_slot = rd_slot_reg;

endmodule

// ===== rtl/fcal_dp.sv =====
// Datapath: lifetime register, frame code registers, three list units, output register.
// Depends on fcal_pkg and fcal_list.
module fcal_dp #(
    parameter int LIST_DEPTH = 15,
    localparam int AW = $clog2(LIST_DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fcal_pkg::fcal_cmd_t            cmd,
    input  logic [AW-1:0]                  slot_addr,
    input  logic [fcal_pkg::APP_W-1:0]     app_idx,
    input  logic [fcal_pkg::LIST_ID_W-1:0] list_sel,
    input  logic [fcal_pkg::LIFE_W-1:0]    entry_lifetime,
    input  logic [fcal_pkg::CODE_W-1:0]    motor_code,
    input  logic [fcal_pkg::CODE_W-1:0]    battery_code,
    input  logic [fcal_pkg::CODE_W-1:0]    other_code_a,
    input  logic [fcal_pkg::CODE_W-1:0]    other_code_b,
    input  logic [fcal_pkg::CODE_W-1:0]    other_code_c,
    input  logic                           out_ready,
    output fcal_pkg::fcal_sts_t            sts,
    output logic                           out_valid,
    output logic [fcal_pkg::LIST_ID_W-1:0] list_id,
    output logic [fcal_pkg::SLOT_W-1:0]    slot,
    output logic [fcal_pkg::CODE_W-1:0]    code,
    output logic                           live_flag,
    output logic [fcal_pkg::CNT_W-1:0]     live_count,
    output logic                           last
);
    import fcal_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic [LIFE_W-1:0]    lifetime_reg;
    logic [CODE_W-1:0]    motor_reg, battery_reg, oa_reg, ob_reg, oc_reg;
    logic [LIST_ID_W-1:0] pend_list_reg;

    logic                 out_valid_reg;
    logic [LIST_ID_W-1:0] list_id_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [CODE_W-1:0]    code_reg;
    logic                 live_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 last_reg;

    fcal_lcmd_t lcmd_bat, lcmd_mot, lcmd_oth;

    logic [CODE_W-1:0] bat_code, mot_code, oth_code, sel_code;
    logic              bat_live, mot_live, oth_live, sel_live;
    logic [CW-1:0]     bat_cnt, mot_cnt, oth_cnt, sel_cnt;
    logic [AW-1:0]     bat_slot, mot_slot, oth_slot, sel_slot;

    // Lifetime register, written through the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg <= LIFETIME_RESET;
        end
        else if (cmd.cfg_wr)
        begin
            lifetime_reg <= entry_lifetime;
        end
    end

    // Frame codes are held for the whole update, and the list of each report read.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            motor_reg   <= motor_code;
            battery_reg <= battery_code;
            oa_reg      <= other_code_a;
            ob_reg      <= other_code_b;
            oc_reg      <= other_code_c;
        end
        if (cmd.rep_rd)
        begin
            pend_list_reg <= list_sel;
        end
    end

    // Per-list commands: report reads and loads go to one list only.
    always_comb
    begin
        lcmd_bat.start    = cmd.start;
        lcmd_bat.scan     = cmd.scan;
        lcmd_bat.append   = cmd.append;
        lcmd_bat.rep_rd   = cmd.rep_rd && (list_sel == LIST_BATTERY);
        lcmd_bat.rep_load = cmd.rep_load && (pend_list_reg == LIST_BATTERY);
        lcmd_mot          = lcmd_bat;
        lcmd_mot.rep_rd   = cmd.rep_rd && (list_sel == LIST_MOTOR);
        lcmd_mot.rep_load = cmd.rep_load && (pend_list_reg == LIST_MOTOR);
        lcmd_oth          = lcmd_bat;
        lcmd_oth.rep_rd   = cmd.rep_rd && (list_sel == LIST_OTHER);
        lcmd_oth.rep_load = cmd.rep_load && (pend_list_reg == LIST_OTHER);
    end

    // The single-code lists take their code in the last position.
    fcal_list #(.DEPTH(LIST_DEPTH)) u_battery (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lcmd_bat),
        .rd_addr  (slot_addr),
        .app_idx  (app_idx),
        .code_a   ('0),
        .code_b   ('0),
        .code_c   (battery_reg),
        .lifetime (lifetime_reg),
        .out_code (bat_code),
        .out_live (bat_live),
        .out_cnt  (bat_cnt),
        .out_slot (bat_slot)
    );

    fcal_list #(.DEPTH(LIST_DEPTH)) u_motor (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lcmd_mot),
        .rd_addr  (slot_addr),
        .app_idx  (app_idx),
        .code_a   ('0),
        .code_b   ('0),
        .code_c   (motor_reg),
        .lifetime (lifetime_reg),
        .out_code (mot_code),
        .out_live (mot_live),
        .out_cnt  (mot_cnt),
        .out_slot (mot_slot)
    );

    fcal_list #(.DEPTH(LIST_DEPTH)) u_other (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (lcmd_oth),
        .rd_addr  (slot_addr),
        .app_idx  (app_idx),
        .code_a   (oa_reg),
        .code_b   (ob_reg),
        .code_c   (oc_reg),
        .lifetime (lifetime_reg),
        .out_code (oth_code),
        .out_live (oth_live),
        .out_cnt  (oth_cnt),
        .out_slot (oth_slot)
    );

    // Select the list whose slot is waiting to be reported.
    always_comb
    begin
        unique case (pend_list_reg)
            LIST_BATTERY:
            begin
                sel_code = bat_code;
                sel_live = bat_live;
                sel_cnt  = bat_cnt;
                sel_slot = bat_slot;
            end
            LIST_MOTOR:
            begin
                sel_code = mot_code;
                sel_live = mot_live;
                sel_cnt  = mot_cnt;
                sel_slot = mot_slot;
            end
            default:
            begin
                sel_code = oth_code;
                sel_live = oth_live;
                sel_cnt  = oth_cnt;
                sel_slot = oth_slot;
            end
        endcase
    end

    // Output register: loads a slot result, empties on a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.rep_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rep_load)
        begin
            list_id_reg <= pend_list_reg;
            slot_reg    <= SLOT_W'(sel_slot);
            code_reg    <= sel_code;
            live_reg    <= sel_live;
            count_reg   <= CNT_W'(sel_cnt);
            last_reg    <= (pend_list_reg == LIST_OTHER) &&
                           (sel_slot == AW'(LIST_DEPTH - 1));
        end
    end

    assign sts.out_valid = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign list_id       = list_id_reg;
    assign slot          = slot_reg;
    assign code          = code_reg;
    assign live_flag     = live_reg;
    assign live_count    = count_reg;
    assign last          = last_reg;

endmodule

// ===== rtl/fcal_ctrl.sv =====
// Controller: sequences frame accept, compaction scan, appends and the report run.
// Depends on fcal_pkg.
module fcal_ctrl #(
    parameter int LIST_DEPTH = 15,
    localparam int AW = $clog2(LIST_DEPTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           out_ready,
    input  fcal_pkg::fcal_sts_t            sts,
    output fcal_pkg::fcal_cmd_t            cmd,
    output logic [AW-1:0]                  slot_addr,
    output logic [fcal_pkg::APP_W-1:0]     app_idx,
    output logic [fcal_pkg::LIST_ID_W-1:0] list_sel
);
    import fcal_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SCAN_END = 3'd2;
    localparam logic [2:0] S_APPEND   = 3'd3;
    localparam logic [2:0] S_REPORT   = 3'd4;
    localparam logic [2:0] S_DRAIN    = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        slot_reg, slot_next;
    logic [APP_W-1:0]     app_reg, app_next;
    logic [LIST_ID_W-1:0] list_reg, list_next;
    logic                 pend_reg, pend_next;

    logic slot_last;
    logic load;
    logic issue;

    assign slot_last = (slot_reg == AW'(LIST_DEPTH - 1));

    // A read slot moves to the output register once that register is free.
    assign load = pend_reg && (!sts.out_valid || out_ready);

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        app_next   = app_reg;
        list_next  = list_reg;
        issue      = 1'b0;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;
        cmd        = '0;
        cmd.rep_load = load;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cfg_ready  = 1'b1;
                cmd.cfg_wr = cfg_valid;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    slot_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (slot_last)
                begin
                    state_next = S_SCAN_END;
                end
                else
                begin
                    slot_next = slot_reg + AW'(1);
                end
            end
            S_SCAN_END:
            begin
                app_next   = APP_A;
                state_next = S_APPEND;
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                if (app_reg == APP_C)
                begin
                    slot_next  = '0;
                    list_next  = LIST_BATTERY;
                    state_next = S_REPORT;
                end
                else
                begin
                    app_next = app_reg + APP_W'(1);
                end
            end
            S_REPORT:
            begin
                issue      = !pend_reg || load;
                cmd.rep_rd = issue;
                if (issue)
                begin
                    if (slot_last)
                    begin
                        slot_next = '0;
                        if (list_reg == LIST_OTHER)
                        begin
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            list_next = list_reg + LIST_ID_W'(1);
                        end
                    end
                    else
                    begin
                        slot_next = slot_reg + AW'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        pend_next = issue ? 1'b1 : (load ? 1'b0 : pend_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            app_reg   <= APP_A;
            list_reg  <= LIST_BATTERY;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            app_reg   <= app_next;
            list_reg  <= list_next;
            pend_reg  <= pend_next;
        end
    end

    assign slot_addr = slot_reg;
    assign app_idx   = app_reg;
    assign list_sel  = list_reg;

endmodule

// ===== rtl/fcal_checker.sv =====
// Port-level checker for the fault code aging lists block, bound to the top level.
// Depends on fcal_pkg and fault_code_aging_lists_assert.svh.
`include "fault_code_aging_lists_assert.svh"

module fcal_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           cfg_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [fcal_pkg::LIST_ID_W-1:0] list_id,
    input logic [fcal_pkg::SLOT_W-1:0]    slot,
    input logic [fcal_pkg::CODE_W-1:0]    code,
    input logic                           live_flag,
    input logic                           last
);
    import fcal_pkg::*;

    // A stalled result keeps its content.
    `FCAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code) && $stable(slot) && $stable(list_id), "result changed while stalled")

    // The block is busy right after a frame transfer.
    `FCAL_ASSERT_NEXT(a_busy_after_frame, in_valid && in_ready, !in_ready && !cfg_ready, "ready stayed high after a frame transfer")

    // Dead slots report a zero code.
    `FCAL_ASSERT_NOW(a_dead_slot_zero, out_valid && !live_flag, code == '0, "dead slot reported a nonzero code")

    // Only the other list closes a frame.
    `FCAL_ASSERT_NOW(a_last_other, out_valid && last, list_id == LIST_OTHER, "last flag outside the other list")

    // Configuration is taken only when a frame could be taken.
    `FCAL_ASSERT_NOW(a_cfg_idle, cfg_ready, in_ready, "configuration ready while busy")

endmodule

bind fault_code_aging_lists fcal_checker u_fcal_checker (.*);
